// ----- hdl/integer_to_ascii_formatter_macros.svh -----
// ============================================================================
// Assertion macros for the integer to ASCII formatter
// Shared property forms, clocked on clk and disabled while rst is high.
// ============================================================================
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ita_pkg.sv -----
// ============================================================================
// Integer to ASCII formatter package
// Types, codes and character helpers shared by the formatter modules.
// ============================================================================
`default_nettype none

package ita_pkg;

  // Digit register: twenty four-bit digits cover any 64-bit value in decimal.
  localparam int DIGIT_COUNT = 20;
  localparam int DIGIT_BITS  = 4;
  localparam int BCD_BITS    = DIGIT_COUNT * DIGIT_BITS;
  localparam int REM_BITS    = 5;

  // Mode codes.
  localparam logic [1:0] MODE_SDEC = 2'd0;
  localparam logic [1:0] MODE_UDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_PTR  = 2'd3;

  // Size codes; any other code means a 64-bit argument.
  localparam logic [1:0] SIZE_16 = 2'd0;
  localparam logic [1:0] SIZE_32 = 2'd1;

  // Characters.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_X       = 8'h78;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;

  // Formatting flags captured when an item is accepted.
  typedef struct packed {
    logic neg;    // print a minus sign first
    logic ptr;    // print "0x" first
    logic hex;    // binary digits, no decimal correction
    logic upper;  // uppercase letters for hex digits
  } fmt_t;

  // Double-dabble correction: add three to every digit that is five or more.
  function automatic logic [BCD_BITS-1:0] add3_all(input logic [BCD_BITS-1:0] bcd);
    logic [BCD_BITS-1:0] res;
    logic [DIGIT_BITS-1:0] d;
    res = bcd;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      d = bcd[i*DIGIT_BITS +: DIGIT_BITS];
      if (d >= 4'd5) begin
        res[i*DIGIT_BITS +: DIGIT_BITS] = d + 4'd3;
      end
    end
    return res;
  endfunction

  // ASCII character for one digit.
  function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d,
                                            input logic upper);
    logic [7:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'h0, d};
    end
    return base + {4'h0, d} - 8'd10;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ita_dabble.sv -----
// ============================================================================
// Bit-serial digit converter
// Shifts the magnitude into a digit register one bit per cycle, applying the
// double-dabble correction in decimal modes and none in hex modes.
// ============================================================================
`default_nettype none

module ita_dabble #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          hex,
  input  wire logic [VALUE_BITS-1:0]         magnitude,
  output logic                               busy,
  output logic                               done,
  output logic [ita_pkg::BCD_BITS-1:0]       digits
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]        sr;
  logic [CNT_W-1:0]             cnt;
  logic                         hex_q;
  logic [ita_pkg::BCD_BITS-1:0] corrected;

  // Correct the digits before each shift unless the digits are hex.
  assign corrected = hex_q ? digits : ita_pkg::add3_all(digits);

  // Control: one shift per cycle until all VALUE_BITS bits are in, then a done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the magnitude leaves MSB first into the digit register.
  always_ff @(posedge clk) begin
    if (start) begin
      sr     <= magnitude;
      hex_q  <= hex;
      digits <= '0;
    end else if (busy) begin
      sr     <= {sr[VALUE_BITS-2:0], 1'b0};
      digits <= {corrected[ita_pkg::BCD_BITS-2:0], sr[VALUE_BITS-1]};
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ita_emit.sv -----
// ============================================================================
// Character emitter
// Sends the prefix, skips leading zero digits and sends the remaining digits
// one character per cycle unless the output is stalled, via a registered output stage.
// ============================================================================
`default_nettype none

module ita_emit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire ita_pkg::fmt_t                 fmt,
  input  wire logic [ita_pkg::BCD_BITS-1:0]  digits,
  output logic                               busy,
  output logic [7:0]                         character,
  output logic                               last,
  output logic                               char_valid,
  input  wire logic                          char_stall
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_PREFIX = 2'd1;
  localparam logic [1:0] ST_SKIP   = 2'd2;
  localparam logic [1:0] ST_DIGIT  = 2'd3;

  localparam int DB = ita_pkg::DIGIT_BITS;
  localparam int BB = ita_pkg::BCD_BITS;

  logic [1:0]                   state;
  logic [BB-1:0]                digs;
  logic [ita_pkg::REM_BITS-1:0] rem;
  logic                         pre_idx;
  logic                         advance;
  logic                         emit_now;
  logic [DB-1:0]                top_dig;

  assign advance  = !char_valid || !char_stall;
  assign emit_now = (state == ST_PREFIX) || (state == ST_DIGIT);
  assign top_dig  = digs[BB-1 -: DB];
  assign busy     = (state != ST_IDLE) || char_valid;

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      char_valid <= 1'b0;
      pre_idx    <= 1'b0;
    end else begin
      if (advance) begin
        char_valid <= emit_now;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            pre_idx <= 1'b0;
            state   <= (fmt.neg || fmt.ptr) ? ST_PREFIX : ST_SKIP;
          end
        end
        ST_PREFIX: begin
          if (advance) begin
            if (fmt.neg || pre_idx) begin
              state <= ST_SKIP;
            end
            pre_idx <= 1'b1;
          end
        end
        ST_SKIP: begin
          if (top_dig != '0 || rem == ita_pkg::REM_BITS'(1)) begin
            state <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (advance && rem == ita_pkg::REM_BITS'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Digit register and output payload.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      digs <= digits;
      rem  <= ita_pkg::REM_BITS'(ita_pkg::DIGIT_COUNT);
    end else if (state == ST_SKIP && top_dig == '0 && rem != ita_pkg::REM_BITS'(1)) begin
      digs <= {digs[BB-DB-1:0], {DB{1'b0}}};
      rem  <= rem - ita_pkg::REM_BITS'(1);
    end else if (state == ST_DIGIT && advance) begin
      digs <= {digs[BB-DB-1:0], {DB{1'b0}}};
      rem  <= rem - ita_pkg::REM_BITS'(1);
    end

    if (advance && state == ST_PREFIX) begin
      last <= 1'b0;
      if (fmt.neg) begin
        character <= ita_pkg::CHAR_MINUS;
      end else if (pre_idx) begin
        character <= ita_pkg::CHAR_X;
      end else begin
        character <= ita_pkg::CHAR_ZERO;
      end
    end else if (advance && state == ST_DIGIT) begin
      character <= ita_pkg::digit_char(top_dig, fmt.upper);
      last      <= (rem == ita_pkg::REM_BITS'(1));
    end
  end

endmodule

`default_nettype wire

// ----- hdl/integer_to_ascii_formatter.sv -----
// ============================================================================
// Integer to ASCII formatter
// Formats one integer as signed or unsigned decimal, lowercase hex or
// "0x"-prefixed uppercase hex, and sends it one character per item.
// ============================================================================
//
// Channel   Direction  Handshake              Payload
// item      in         item_valid/item_stall  value[63:0], size_code[1:0], mode[1:0]
// char      out        char_valid/char_stall  character[7:0], last
//
// An item passes through the bit-serial converter (one bit per cycle) and the
// hand-over to the emitter, then its prefix characters, then the steps that
// skip leading zero digits and send the rest, one digit per cycle while the
// output is not stalled. One item is in flight at a time; item_stall stays high
// until its last character has been taken. Stalls on char hold the output
// register and the prefix and digit steps; leading-zero skipping goes on under
// a stall. Reset is synchronous and clears all control state.
// ============================================================================
`default_nettype none

module integer_to_ascii_formatter #(
  parameter int VALUE_BITS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [63:0] value,
  input  wire logic [1:0]  size_code,
  input  wire logic [1:0]  mode,
  output logic             char_valid,
  input  wire logic        char_stall,
  output logic [7:0]       character,
  output logic             last
);

  localparam int W32 = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam logic [VALUE_BITS-1:0] MASK16 = VALUE_BITS'((65'd1 << 16) - 65'd1);
  localparam logic [VALUE_BITS-1:0] MASK32 = VALUE_BITS'((65'd1 << W32) - 65'd1);
  localparam logic [VALUE_BITS-1:0] MASKVB = VALUE_BITS'((65'd1 << VALUE_BITS) - 65'd1);

  logic                         accept;
  logic                         dab_busy;
  logic                         dab_done;
  logic                         emit_busy;
  logic [ita_pkg::BCD_BITS-1:0] digits;
  logic [VALUE_BITS-1:0]        trunc;
  logic [VALUE_BITS-1:0]        mask;
  logic                         sign;
  logic [VALUE_BITS-1:0]        magnitude;
  ita_pkg::fmt_t                fmt_in;
  ita_pkg::fmt_t                fmt;

  assign item_stall = dab_busy || dab_done || emit_busy;
  assign accept     = item_valid && !item_stall;

  // Truncate to the argument size and find its sign bit.
  always_comb begin
    case (size_code)
      ita_pkg::SIZE_16: begin
        mask = MASK16;
        sign = value[15];
      end
      ita_pkg::SIZE_32: begin
        mask = MASK32;
        sign = value[W32-1];
      end
      default: begin
        mask = MASKVB;
        sign = value[VALUE_BITS-1];
      end
    endcase
    trunc = value[VALUE_BITS-1:0] & mask;
  end

  // Formatting flags; a negative signed value is negated within its width.
  always_comb begin
    fmt_in.neg   = (mode == ita_pkg::MODE_SDEC) && sign;
    fmt_in.ptr   = (mode == ita_pkg::MODE_PTR);
    fmt_in.hex   = (mode == ita_pkg::MODE_HEX) || (mode == ita_pkg::MODE_PTR);
    fmt_in.upper = (mode == ita_pkg::MODE_PTR);
    magnitude    = fmt_in.neg ? ((~trunc + VALUE_BITS'(1)) & mask) : trunc;
  end

  // Flags are held for the whole item.
  always_ff @(posedge clk) begin
    if (accept) begin
      fmt <= fmt_in;
    end
  end

  ita_dabble #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .hex       (fmt_in.hex),
    .magnitude (magnitude),
    .busy      (dab_busy),
    .done      (dab_done),
    .digits    (digits)
  );

  ita_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .start      (dab_done),
    .fmt        (fmt),
    .digits     (digits),
    .busy       (emit_busy),
    .character  (character),
    .last       (last),
    .char_valid (char_valid),
    .char_stall (char_stall)
  );

endmodule

`default_nettype wire

// ----- hdl/ita_chk.sv -----
// ============================================================================
// Integer to ASCII formatter port checker
// Watches the top-level ports for handshake and sequencing slips.
// ============================================================================
`default_nettype none

`include "integer_to_ascii_formatter_macros.svh"

module ita_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       item_valid,
  input wire logic       item_stall,
  input wire logic       char_valid,
  input wire logic       char_stall,
  input wire logic [7:0] character,
  input wire logic       last
);

  // A stalled character item stays offered and unchanged.
  `ITA_ASSERT_NEXT(a_char_hold, char_valid && char_stall, char_valid && $stable(character) && $stable(last), "stalled character item changed")

  // An accepted input item makes the block busy.
  `ITA_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "block not busy after accepting an item")

  // No input item is taken while a character is waiting.
  `ITA_ASSERT_NOW(a_stall_while_output, char_valid, item_stall, "input open while a character is pending")

  // The last character of a number ends the output burst.
  `ITA_ASSERT_NEXT(a_gap_after_last, char_valid && !char_stall && last, !char_valid, "character item right after the last one")

endmodule

bind integer_to_ascii_formatter ita_chk u_ita_chk (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item_valid),
  .item_stall (item_stall),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .character  (character),
  .last       (last)
);

`default_nettype wire

// ----- tb/sv/integer_to_ascii_formatter_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Testbench for the integer to ASCII formatter
// Sends numbers in every mode and size code and checks each character against
// a local model. Directed corner values come first, then random values in
// three idling phases. Long output stalls and full drains are included.
// ============================================================================

module integer_to_ascii_formatter_tb;

  localparam int VALUE_BITS = 64;
  localparam int MAX_CHARS  = 20;
  localparam int RANDOM_PER_PHASE = 160;
  localparam int SETTLE_CYCLES = 150;

  // Size codes that the package leaves unnamed.
  localparam logic [1:0] SIZE_64       = 2'd2;
  localparam logic [1:0] SIZE_RESERVED = 2'd3;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  size_code;
    logic [1:0]  mode;
  } number_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [63:0] value = '0;
  logic [1:0]  size_code = '0;
  logic [1:0]  mode = '0;
  logic        char_valid;
  logic        char_stall = 1'b0;
  logic [7:0]  character;
  logic        last;

  number_t    pending_numbers[$];
  text_char_t expected_text[$];
  number_t    next_number;
  text_char_t want;

  int unsigned send_idle_pct = 34;
  int unsigned recv_idle_pct = 57;
  int          numbers_sent = 0;
  int          chars_checked = 0;
  int          failures = 0;
  int          mode_count[4] = '{0, 0, 0, 0};
  int          hold_left = 0;
  int          hold_seen = 0;

  integer_to_ascii_formatter #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .size_code  (size_code),
    .mode       (mode),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .character  (character),
    .last       (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Appends the text of one number to the expected characters.
  function automatic void format_integer(input logic [63:0] raw, input logic [1:0] sz,
                                         input logic [1:0] md);
    int unsigned width;
    logic [63:0] msk;
    logic [63:0] v;
    logic [63:0] radix;
    logic [3:0]  d;
    logic [7:0]  letter_a;
    logic [7:0]  txt[$];
    logic [7:0]  digits[$];
    text_char_t  tc;
    width = (sz == ita_pkg::SIZE_16) ? 16 : (sz == ita_pkg::SIZE_32) ? 32 : 64;
    if (VALUE_BITS < width) width = VALUE_BITS;
    msk = (width >= 64) ? '1 : ((64'd1 << width) - 64'd1);
    v = raw & msk;
    radix = (md == ita_pkg::MODE_HEX || md == ita_pkg::MODE_PTR) ? 64'd16 : 64'd10;
    letter_a = (md == ita_pkg::MODE_PTR) ? ita_pkg::CHAR_UPPER_A : ita_pkg::CHAR_LOWER_A;
    // A negative signed value prints its magnitude, taken within the width.
    if (md == ita_pkg::MODE_SDEC && v[width-1]) begin
      txt.push_back(ita_pkg::CHAR_MINUS);
      v = (~v + 64'd1) & msk;
    end
    if (md == ita_pkg::MODE_PTR) begin
      txt.push_back(ita_pkg::CHAR_ZERO);
      txt.push_back(ita_pkg::CHAR_X);
    end
    // Digits come out least significant first.
    if (v == 64'd0) digits.push_back(ita_pkg::CHAR_ZERO);
    while (v != 64'd0 && digits.size() < MAX_CHARS) begin
      d = 4'(v % radix);
      if (d < 4'd10) digits.push_back(ita_pkg::CHAR_ZERO + 8'(d));
      else digits.push_back(letter_a + 8'(d) - 8'd10);
      v = v / radix;
    end
    while (digits.size() > 0 && txt.size() < MAX_CHARS) txt.push_back(digits.pop_back());
    foreach (txt[i]) begin
      tc.character = txt[i];
      tc.last = (i == txt.size() - 1);
      expected_text.push_back(tc);
    end
  endfunction

  // Random operand biased toward digit-count and sign boundaries.
  function automatic logic [63:0] random_operand();
    logic [63:0] r;
    logic [63:0] p;
    logic [63:0] b;
    logic [63:0] msk;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return r;
      1: return 64'($urandom_range(20));
      2: return r >> $urandom_range(63);
      3: begin
        p = 64'd1;
        repeat ($urandom_range(19)) p = p * 64'd10;
        return p + 64'($urandom_range(2)) - 64'd1;
      end
      4: begin
        // Around the sign bit of a random width, with junk above it.
        b = 64'd1 << ((16 << $urandom_range(2)) - 1);
        msk = (b << 1) - 64'd1;
        return (r & ~msk) | ((b + 64'($urandom_range(2)) - 64'd1) & msk);
      end
      default: return r | ((64'd1 << (16 << $urandom_range(2))) - 64'd1);
    endcase
  endfunction

  task automatic queue_number(input logic [63:0] v, input logic [1:0] sz,
                              input logic [1:0] md);
    number_t n;
    n.value = v;
    n.size_code = sz;
    n.mode = md;
    pending_numbers.push_back(n);
  endtask

  // Holds the stimulus back until every number has been sent and printed.
  task automatic wait_for_drain();
    while (pending_numbers.size() > 0 || item_valid || expected_text.size() > 0)
      @(negedge clk);
  endtask

  // Sender: predicts on acceptance, then offers the next number or idles.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        format_integer(value, size_code, mode);
        numbers_sent <= numbers_sent + 1;
        mode_count[mode]++;
      end
      if (!item_valid || !item_stall) begin
        if (pending_numbers.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_number = pending_numbers.pop_front();
          item_valid <= 1'b1;
          value <= next_number.value;
          size_code <= next_number.size_code;
          mode <= next_number.mode;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Long output stall, started twice while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if ((numbers_sent == 60 || numbers_sent == 420) && numbers_sent != hold_seen) begin
      hold_left <= 250;
      hold_seen <= numbers_sent;
    end
  end

  // Receiver: checks each accepted character, then picks the next stall.
  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, character, last);
          failures++;
        end else begin
          want = expected_text.pop_front();
          chars_checked++;
          if (character !== want.character) begin
            $display("%0t: character mismatch: expected %h, actual %h",
                     $time, want.character, character);
            failures++;
          end
          if (last !== want.last) begin
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, last);
            failures++;
          end
        end
      end
      char_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Stimulus and end of run.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corners: zero, extremes, most negative values, truncation.
    queue_number(64'd0, ita_pkg::SIZE_16, ita_pkg::MODE_SDEC);
    queue_number(64'h0000_0000_0000_7FFF, ita_pkg::SIZE_16, ita_pkg::MODE_SDEC);
    queue_number(64'hDEAD_BEEF_1234_8000, ita_pkg::SIZE_16, ita_pkg::MODE_SDEC);
    queue_number(64'h0000_0000_0000_FFFF, ita_pkg::SIZE_16, ita_pkg::MODE_SDEC);
    queue_number(64'h0000_0000_8000_0000, ita_pkg::SIZE_32, ita_pkg::MODE_SDEC);
    queue_number(64'hFFFF_FFFF_7FFF_FFFF, ita_pkg::SIZE_32, ita_pkg::MODE_SDEC);
    queue_number(64'h8000_0000_0000_0000, SIZE_64, ita_pkg::MODE_SDEC);
    queue_number(64'h7FFF_FFFF_FFFF_FFFF, SIZE_64, ita_pkg::MODE_SDEC);
    queue_number('1, SIZE_64, ita_pkg::MODE_SDEC);
    queue_number('1, SIZE_64, ita_pkg::MODE_UDEC);
    queue_number(64'd0, SIZE_64, ita_pkg::MODE_UDEC);
    queue_number('1, ita_pkg::SIZE_16, ita_pkg::MODE_UDEC);
    queue_number(64'hFFFF_FFFF_FFFF_FFFF, ita_pkg::SIZE_32, ita_pkg::MODE_UDEC);
    queue_number(64'd0, ita_pkg::SIZE_16, ita_pkg::MODE_HEX);
    queue_number(64'h1234_5678_9ABC_ABCD, ita_pkg::SIZE_16, ita_pkg::MODE_HEX);
    queue_number('1, SIZE_64, ita_pkg::MODE_HEX);
    queue_number(64'h0123_4567_DEAD_BEEF, ita_pkg::SIZE_32, ita_pkg::MODE_HEX);
    queue_number(64'd0, SIZE_64, ita_pkg::MODE_PTR);
    queue_number(64'hFFFF_0000_0000_00FE, ita_pkg::SIZE_16, ita_pkg::MODE_PTR);
    queue_number('1, SIZE_64, ita_pkg::MODE_PTR);
    queue_number(64'h8000_0000_0000_0000, SIZE_RESERVED, ita_pkg::MODE_SDEC);
    queue_number(64'hFEDC_BA98_7654_3210, SIZE_RESERVED, ita_pkg::MODE_HEX);
    queue_number(64'd9, SIZE_RESERVED, ita_pkg::MODE_UDEC);
    queue_number(64'h0000_0000_0000_0010, ita_pkg::SIZE_32, ita_pkg::MODE_PTR);

    // Random numbers, sender idling less than the receiver.
    repeat (RANDOM_PER_PHASE)
      queue_number(random_operand(), 2'($urandom_range(3)), 2'($urandom_range(3)));
    wait_for_drain();

    // Random numbers, receiver idling less than the sender.
    send_idle_pct = 57;
    recv_idle_pct = 34;
    repeat (RANDOM_PER_PHASE)
      queue_number(random_operand(), 2'($urandom_range(3)), 2'($urandom_range(3)));
    wait_for_drain();

    // Random numbers at full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (RANDOM_PER_PHASE)
      queue_number(random_operand(), 2'($urandom_range(3)), 2'($urandom_range(3)));
    wait_for_drain();

    // Let any stray characters show up before the verdict.
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_text.size() != 0) begin
      $display("%0t: %0d expected characters never arrived", $time, expected_text.size());
      failures++;
    end

    $display("Formatted %0d numbers: %0d signed, %0d unsigned, %0d hex, %0d pointer.",
             numbers_sent, mode_count[ita_pkg::MODE_SDEC], mode_count[ita_pkg::MODE_UDEC],
             mode_count[ita_pkg::MODE_HEX], mode_count[ita_pkg::MODE_PTR]);
    $display("Checked %0d characters with %0d mismatches.", chars_checked, failures);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung block.
  initial begin
    #8_000_000;
    $display("%0t: run timed out", $time);
    $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ita_pkg.sv
hdl/ita_dabble.sv
hdl/ita_emit.sv
hdl/integer_to_ascii_formatter.sv
hdl/ita_chk.sv
tb/sv/integer_to_ascii_formatter_tb.sv
